// ===== hw/rtl/estm_pkg.sv =====
package estm_pkg;

  // Field and register widths
  localparam int RAW_W      = 48;
  localparam int FRAC_W     = 16;
  localparam int SPD_W      = 16;
  localparam int TURN_W     = 32;
  localparam int CNT_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_FORWARD  = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]  WINDOW_RST = 16'd126;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 32'd65536;
  localparam logic              FWD_RST    = 1'b1;

  // Trim window in percent of the filter depth
  localparam int TRIM_LO_PCT = 15;
  localparam int TRIM_HI_PCT = 85;
  localparam int PCT_DEN     = 100;

  // Largest speed at which the actual direction follows the command
  localparam logic signed [SPD_W-1:0] SETTLE_MAX = 16'sd10;
  localparam logic signed [SPD_W-1:0] SPD_MAX    = 16'sh7fff;
  localparam logic signed [SPD_W-1:0] SPD_MIN    = 16'sh8000;
  localparam int SPD_LIMIT = 32768;

  function automatic int trim_lo(int depth);
    int raw;
    raw = depth * TRIM_LO_PCT / PCT_DEN;
    return (raw > 1) ? raw : 1;
  endfunction

  function automatic int trim_hi(int depth);
    int raw;
    raw = depth * TRIM_HI_PCT / PCT_DEN + 1;
    return (raw < depth - 1) ? raw : depth - 1;
  endfunction

  // Dividend bits needed below the saturation limit
  function automatic int div_bits(int depth);
    return $clog2((trim_hi(depth) - trim_lo(depth)) * SPD_LIMIT);
  endfunction

  typedef struct packed {
    logic accept;    // input transaction taken
    logic mul;       // form gain times count
    logic ring_wr;   // write raw speed into the history ring
    logic copy;      // copy ring into scratch, clear sum
    logic sort;      // one compare-exchange pass
    logic sort_odd;  // pass pairs start at odd index
    logic shift;     // shift scratch down by one
    logic add;       // add scratch head into sum
    logic prep;      // take magnitude, load divider
    logic div;       // divide by the trim count
    logic load;      // load result register
  } estm_cmd_t;

  typedef struct packed {
    logic close;     // next sample ends the window
  } estm_sts_t;

endpackage

// ===== hw/rtl/estm_dp.sv =====
module estm_dp
  import estm_pkg::*;
#(
  parameter int FILTER_DEPTH = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  estm_cmd_t                cmd_i,
  output estm_sts_t                sts_o,
  input  logic                     enc_a_i,
  input  logic                     enc_b_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output logic signed [SPD_W-1:0]  filtered_speed_o,
  output logic signed [TURN_W-1:0] turn_total_o,
  output logic                     actual_forward_o
);

  localparam int IdxW    = $clog2(FILTER_DEPTH);
  localparam int SumW    = RAW_W + $clog2(FILTER_DEPTH);
  localparam int MagW    = SumW - FRAC_W;
  localparam int TrimCnt = trim_hi(FILTER_DEPTH) - trim_lo(FILTER_DEPTH);
  localparam int SatLim  = TrimCnt * SPD_LIMIT;
  localparam int NumW    = div_bits(FILTER_DEPTH);
  // Reciprocal of the trim count, exact for every dividend below NumW bits
  localparam int RecipSh = NumW + $clog2(TrimCnt);
  localparam int Recip   = ((1 << RecipSh) + TrimCnt - 1) / TrimCnt;
  localparam int ProdW   = NumW + RecipSh;
  localparam logic [NumW:0] RecipK = (NumW+1)'(Recip);

  // Configuration
  logic [CNT_W-1:0]  window_q;
  logic [GAIN_W-1:0] gain_q;
  logic              fwd_q;

  // Window counters and direction state
  logic              prev_xor_q;
  logic [CNT_W-1:0]  edge_q;
  logic [CNT_W-1:0]  tick_q;
  logic [TURN_W-1:0] turn_q;
  logic              dir_q;
  logic [IdxW-1:0]   ring_idx_q;
  logic signed [RAW_W-1:0] ring_q [FILTER_DEPTH];

  // Filter datapath
  logic [CNT_W-1:0]        cnt_q;
  logic [RAW_W-1:0]        mag_q;
  logic signed [RAW_W-1:0] scratch_q [FILTER_DEPTH];
  logic signed [RAW_W-1:0] sorted_d  [FILTER_DEPTH];
  logic signed [SumW-1:0]  sum_q;
  logic                    neg_q;
  logic                    sat_q;
  logic [NumW-1:0]         num_q;
  logic [NumW-1:0]         quo_q;

  logic signed [SPD_W-1:0]  speed_q;
  logic signed [TURN_W-1:0] turn_out_q;
  logic                     actual_q;

  logic              xor_s;
  logic [CNT_W-1:0]  edge_inc;
  logic [CNT_W-1:0]  tick_inc;
  logic [IdxW-1:0]   idx_nxt;
  logic [RAW_W-1:0]  mag_sat;
  logic signed [RAW_W-1:0] raw;
  logic [SumW-1:0]   sum_abs;
  logic [MagW-1:0]   sum_int;
  logic [ProdW-1:0]  prod;
  logic signed [SPD_W-1:0] spd_d;
  logic              settle;

  assign xor_s    = enc_a_i ^ enc_b_i;
  assign edge_inc = ((xor_s != prev_xor_q) && (edge_q != '1)) ? edge_q + 1'b1 : edge_q;
  assign tick_inc = (tick_q != '1) ? tick_q + 1'b1 : tick_q;
  assign sts_o.close = (tick_inc >= window_q);

  assign idx_nxt = (ring_idx_q == IdxW'(FILTER_DEPTH - 1)) ? '0 : ring_idx_q + 1'b1;
  // Clamp magnitude to the largest positive raw value before signing
  assign mag_sat = mag_q[RAW_W-1] ? {1'b0, {(RAW_W-1){1'b1}}} : mag_q;
  assign raw     = dir_q ? signed'(mag_sat) : -signed'(mag_sat);

  // Odd-even transposition pass
  always_comb begin
    for (int i = 0; i < FILTER_DEPTH; i++) begin
      sorted_d[i] = scratch_q[i];
      if (((i % 2) == int'(cmd_i.sort_odd)) && (i + 1 < FILTER_DEPTH)) begin
        if (scratch_q[i] > scratch_q[i+1]) sorted_d[i] = scratch_q[i+1];
      end else if ((i >= 1) && (((i - 1) % 2) == int'(cmd_i.sort_odd))) begin
        if (scratch_q[i-1] > scratch_q[i]) sorted_d[i] = scratch_q[i-1];
      end
    end
  end

  assign sum_abs = sum_q[SumW-1] ? unsigned'(-sum_q) : unsigned'(sum_q);
  assign sum_int = sum_abs[SumW-1:FRAC_W];

  // NumW by NumW+1 bit product; the quotient sits above RecipSh
  assign prod = ProdW'(num_q) * ProdW'(RecipK);

  always_comb begin
    if (sat_q) begin
      spd_d = neg_q ? SPD_MIN : SPD_MAX;
    end else if (neg_q) begin
      spd_d = -signed'(quo_q[SPD_W-1:0]);
    end else begin
      spd_d = signed'(quo_q[SPD_W-1:0]);
    end
  end
  assign settle = !spd_d[SPD_W-1] && (spd_d <= SETTLE_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RST;
      gain_q   <= GAIN_RST;
      fwd_q    <= FWD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_TICKS: window_q <= cfg_data_i[CNT_W-1:0];
        REG_SPEED_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        REG_CMD_FORWARD:  fwd_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_xor_q <= 1'b0;
      edge_q     <= '0;
      tick_q     <= '0;
      turn_q     <= '0;
      dir_q      <= 1'b1;
      ring_idx_q <= '0;
      for (int i = 0; i < FILTER_DEPTH; i++) ring_q[i] <= '0;
    end else begin
      if (cmd_i.accept) begin
        prev_xor_q <= xor_s;
        if (sts_o.close) begin
          edge_q <= '0;
          tick_q <= '0;
          turn_q <= fwd_q ? turn_q + TURN_W'(edge_inc) : turn_q - TURN_W'(edge_inc);
        end else begin
          edge_q <= edge_inc;
          tick_q <= tick_inc;
        end
      end
      if (cmd_i.ring_wr) begin
        ring_q[idx_nxt] <= raw;
        ring_idx_q      <= idx_nxt;
      end
      if (cmd_i.load && settle) dir_q <= fwd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) cnt_q <= edge_inc;
    if (cmd_i.mul) mag_q <= gain_q * cnt_q;
    if (cmd_i.copy) begin
      scratch_q <= ring_q;
      sum_q     <= '0;
    end else if (cmd_i.sort) begin
      scratch_q <= sorted_d;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < FILTER_DEPTH - 1; i++) scratch_q[i] <= scratch_q[i+1];
      if (cmd_i.add) sum_q <= sum_q + SumW'(scratch_q[0]);
    end
    if (cmd_i.prep) begin
      neg_q <= sum_q[SumW-1];
      sat_q <= (sum_int >= MagW'(SatLim));
      num_q <= sum_int[NumW-1:0];
      quo_q <= '0;
    end else if (cmd_i.div) begin
      quo_q <= prod[RecipSh +: NumW];
    end
    if (cmd_i.load) begin
      speed_q    <= spd_d;
      turn_out_q <= signed'(turn_q);
      actual_q   <= settle ? fwd_q : dir_q;
    end
  end

  assign filtered_speed_o = speed_q;
  assign turn_total_o     = turn_out_q;
  assign actual_forward_o = actual_q;

endmodule

// ===== hw/rtl/estm_ctrl.sv =====
module estm_ctrl
  import estm_pkg::*;
#(
  parameter int FILTER_DEPTH = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  estm_sts_t sts_i,
  output estm_cmd_t cmd_o
);

  localparam int CntW  = $clog2(FILTER_DEPTH);
  localparam int TrimL = trim_lo(FILTER_DEPTH);
  localparam int TrimH = trim_hi(FILTER_DEPTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_RING = 4'd2;
  localparam logic [3:0] ST_COPY = 4'd3;
  localparam logic [3:0] ST_SORT = 4'd4;
  localparam logic [3:0] ST_SUM  = 4'd5;
  localparam logic [3:0] ST_PREP = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.close) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RING;
      end
      ST_RING: begin
        cmd_o.ring_wr = 1'b1;
        state_d       = ST_COPY;
      end
      ST_COPY: begin
        cmd_o.copy = 1'b1;
        step_d     = '0;
        state_d    = ST_SORT;
      end
      ST_SORT: begin
        cmd_o.sort     = 1'b1;
        cmd_o.sort_odd = step_q[0];
        step_d         = step_q + 1'b1;
        if (step_q == CntW'(FILTER_DEPTH - 1)) begin
          step_d  = '0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        // Stream sorted entries through the head, keep the middle ones
        cmd_o.shift = 1'b1;
        cmd_o.add   = (step_q >= CntW'(TrimL));
        step_d      = step_q + 1'b1;
        if (step_q == CntW'(TrimH - 1)) state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/encoder_speed_trimmed_mean_top.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    enc_a_i, enc_b_i
// out       output     out_valid_o / out_stall_i  filtered_speed_o, turn_total_o,
//                                                 actual_forward_o
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A sample that does not close a window is taken in the idle state. A closing
// sample runs the multiply, ring write, copy, the odd-even sort passes over the
// scratch copy, the streamed sum of the trimmed entries, prep, divide and load.
// Samples are taken while a result waits in the output register; a closing
// sample that finds it full holds in its last state and stalls the input.
// Reset clears the counters, the history ring, the turn total, and sets forward.
module encoder_speed_trimmed_mean_top
  import estm_pkg::*;
#(
  parameter int FILTER_DEPTH = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     enc_a_i,
  input  logic                     enc_b_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [SPD_W-1:0]  filtered_speed_o,
  output logic signed [TURN_W-1:0] turn_total_o,
  output logic                     actual_forward_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  estm_cmd_t cmd;
  estm_sts_t sts;

  estm_ctrl #(
    .FILTER_DEPTH(FILTER_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  estm_dp #(
    .FILTER_DEPTH(FILTER_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .enc_a_i         (enc_a_i),
    .enc_b_i         (enc_b_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .filtered_speed_o(filtered_speed_o),
    .turn_total_o    (turn_total_o),
    .actual_forward_o(actual_forward_o)
  );

endmodule
